// ===== rtl/c2p_pkg.sv =====
package c2p_pkg;

    localparam int WORK_FRAC      = 10;
    localparam int MAX_ITER       = 24;
    localparam int ITERATIONS_DEF = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int RADIUS_BITS    = 24;
    localparam int ANGLE_BITS     = 16;
    localparam int PI_Q14         = 51472;
    localparam int PI_Q13         = 25736;

    // arctan(2^-i) in unsigned Q0.14, rounded to nearest
    function automatic logic [13:0] atan_q14(input logic [4:0] idx);
        logic [13:0] v;
        unique case (idx)
            5'd0:    v = 14'd12868;
            5'd1:    v = 14'd7596;
            5'd2:    v = 14'd4014;
            5'd3:    v = 14'd2037;
            5'd4:    v = 14'd1023;
            5'd5:    v = 14'd512;
            5'd6:    v = 14'd256;
            5'd7:    v = 14'd128;
            5'd8:    v = 14'd64;
            5'd9:    v = 14'd32;
            5'd10:   v = 14'd16;
            5'd11:   v = 14'd8;
            5'd12:   v = 14'd4;
            5'd13:   v = 14'd2;
            5'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    // restoring division, one quotient bit per step. Elaboration only.
    function automatic logic [63:0] div_u64(input logic [63:0] num,
                                            input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int          j;
        q   = '0;
        rem = '0;
        for (j = 63; j >= 0; j--) begin
            rem = {rem[63:0], num[j]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // CORDIC gain correction prod 1/sqrt(1+4^-i) over n terms, Q31.
    // Elaboration only.
    function automatic logic [31:0] gain_q31(input int n);
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] b;
        int          i;
        int          k;
        p = 64'd1 << 62;
        for (i = 0; i < n; i++) begin
            p = p - div_u64(p, (64'd1 << (2 * i)) + 64'd1);
        end
        r = '0;
        b = 64'd1 << 62;
        for (k = 0; k < 32; k++) begin
            if (p >= r + b) begin
                p = p - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

endpackage

// ===== rtl/cartesian_to_polar_converter_top.sv =====
// Cartesian to polar converter: a CORDIC engine in vectoring mode turns one signed point
// (x, y) into radius sqrt(x^2+y^2) (unsigned, 8 fraction bits) and angle atan2(y, x)
// (signed Q3.13 radians, -pi..pi; origin gives 0, negative x axis gives +pi). One
// shared add/shift unit runs one micro-rotation per cycle. An item goes through the accept
// and quadrant fold, then the rotations, then the gain-correction multiply, then rounding;
// ready is high only in the idle state, so the next item is accepted only after rounding.
// The finished result sits in an output register, so a new item is taken while it waits;
// the rounding state stalls only while the previous result is still held.
module cartesian_to_polar_converter_top
    import c2p_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_BITS-1:0]  i_x_coord,
    input  logic signed [COORD_BITS-1:0]  i_y_coord,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic        [RADIUS_BITS-1:0] o_radius,
    output logic signed [ANGLE_BITS-1:0]  o_angle
);

    localparam int N_ITER = (ITERATIONS > MAX_ITER) ? MAX_ITER : ITERATIONS;
    localparam int CW     = (N_ITER > 1) ? $clog2(N_ITER) : 1;
    localparam int W      = COORD_BITS + WORK_FRAC + 3;
    localparam int AW     = 19;
    localparam logic [31:0] GAIN = gain_q31(N_ITER);
    localparam logic [CW-1:0] LAST_STEP = CW'(N_ITER - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ITER,
        S_MUL,
        S_FIN
    } t_state;

    t_state                    r_state;
    logic signed [W-1:0]       r_wx;
    logic signed [W-1:0]       r_wy;
    logic signed [AW-1:0]      r_z;
    logic        [CW-1:0]      r_step;
    logic                      r_y_zero;
    logic                      r_x_neg;
    logic        [60:0]        r_prod;
    logic                      r_rad_zero;
    logic                      r_rad_sat;
    logic signed [ANGLE_BITS-1:0] r_ang;
    logic                      r_out_valid;
    logic        [RADIUS_BITS-1:0] r_radius;
    logic signed [ANGLE_BITS-1:0]  r_angle;

    // fold of the incoming point
    logic signed [W-1:0]  s_x;
    logic signed [W-1:0]  s_y;
    logic signed [W-1:0]  n_wx_load;
    logic signed [W-1:0]  n_wy_load;
    logic signed [AW-1:0] n_z_load;

    // shared rotation unit
    logic signed [W-1:0]  s_dx;
    logic signed [W-1:0]  s_dy;
    logic signed [AW-1:0] s_atan;
    logic signed [W-1:0]  n_wx_rot;
    logic signed [W-1:0]  n_wy_rot;
    logic signed [AW-1:0] n_z_rot;

    // multiply and angle stage
    logic signed [63:0]   s_wx64;
    logic        [60:0]   n_prod;
    logic signed [AW-1:0] s_clamp;
    logic signed [AW-1:0] s_round;

    // rounding stage
    logic        [60:0]   s_sum;
    logic        [27:0]   s_rad_full;
    logic [RADIUS_BITS-1:0] n_radius;

    always_comb begin
        s_x = W'(i_x_coord);
        s_y = W'(i_y_coord);
        if (i_x_coord < 0) begin
            n_wx_load = (-s_x) <<< WORK_FRAC;
            n_wy_load = (-s_y) <<< WORK_FRAC;
            n_z_load  = (i_y_coord >= 0) ? AW'(PI_Q14) : -AW'(PI_Q14);
        end else begin
            n_wx_load = s_x <<< WORK_FRAC;
            n_wy_load = s_y <<< WORK_FRAC;
            n_z_load  = '0;
        end
    end

    always_comb begin
        s_dx   = r_wy >>> r_step;
        s_dy   = r_wx >>> r_step;
        s_atan = AW'(atan_q14(5'(r_step)));
        if (!r_wy[W-1]) begin
            n_wx_rot = r_wx + s_dx;
            n_wy_rot = r_wy - s_dy;
            n_z_rot  = r_z + s_atan;
        end else begin
            n_wx_rot = r_wx - s_dx;
            n_wy_rot = r_wy + s_dy;
            n_z_rot  = r_z - s_atan;
        end
    end

    always_comb begin
        s_wx64 = 64'(r_wx);
        n_prod = 61'(s_wx64[28:0]) * 61'(GAIN);
        if (r_y_zero) begin
            s_clamp = r_x_neg ? AW'(PI_Q14) : '0;
        end else if (r_z > AW'(PI_Q14)) begin
            s_clamp = AW'(PI_Q14);
        end else if (r_z < -AW'(PI_Q14)) begin
            s_clamp = -AW'(PI_Q14);
        end else begin
            s_clamp = r_z;
        end
        s_round = (s_clamp + AW'(1)) >>> 1;
    end

    always_comb begin
        s_sum      = r_prod + (61'd1 << 32);
        s_rad_full = s_sum[60:33];
        if (r_rad_zero) begin
            n_radius = '0;
        end else if (r_rad_sat || (|s_rad_full[27:RADIUS_BITS])) begin
            n_radius = '1;
        end else begin
            n_radius = s_rad_full[RADIUS_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wx        <= '0;
            r_wy        <= '0;
            r_z         <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_wx     <= n_wx_load;
                        r_wy     <= n_wy_load;
                        r_z      <= n_z_load;
                        r_step   <= '0;
                        r_y_zero <= (i_y_coord == '0);
                        r_x_neg  <= i_x_coord[COORD_BITS-1];
                        r_state  <= S_ITER;
                    end
                end
                S_ITER: begin
                    r_wx   <= n_wx_rot;
                    r_wy   <= n_wy_rot;
                    r_z    <= n_z_rot;
                    r_step <= r_step + CW'(1);
                    if (r_step == LAST_STEP) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod     <= n_prod;
                    r_rad_zero <= (r_wx <= 0);
                    r_rad_sat  <= (s_wx64 >= 64'sd536870912);
                    r_ang      <= ANGLE_BITS'(s_round);
                    r_state    <= S_FIN;
                end
                S_FIN: begin
                    // wait here only while the previous result is still held
                    if (!r_out_valid || i_ready) begin
                        r_radius    <= n_radius;
                        r_angle     <= r_ang;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_radius = r_radius;
    assign o_angle  = r_angle;

endmodule

// ===== rtl/c2p_checker.sv =====
module c2p_checker
    import c2p_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic        [RADIUS_BITS-1:0] o_radius,
    input logic signed [ANGLE_BITS-1:0]  o_angle
);

    // held result must not move while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_radius) && $stable(o_angle)))
        else $error("result changed while stalled");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_angle <= ANGLE_BITS'(PI_Q13)) && (o_angle >= -ANGLE_BITS'(PI_Q13))))
        else $error("angle outside -pi..pi");

    // an accepted item keeps the engine busy, holding ready low
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (!o_ready ##1 !o_ready))
        else $error("ready returned too early after an item");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("bad state after reset");

endmodule

bind cartesian_to_polar_converter_top c2p_checker u_c2p_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_radius (o_radius),
    .o_angle  (o_angle)
);
